[rtl/mcfp_pkg.sv]
package mcfp_pkg;

	// Widths fixed by the item fields.
	localparam int CAP_W  = 9;
	localparam int PTR_W  = 8;
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		CMD_CREATE  = 2'd0,
		CMD_SEND    = 2'd1,
		CMD_RECEIVE = 2'd2,
		CMD_CLOSE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOT_OPEN = 3'd1,
		ST_BAD_CAP  = 3'd2,
		ST_NO_FREE  = 3'd3,
		ST_FULL     = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_POP
	} fsm_state_t;

	// Per-channel descriptor held in the descriptor memory.
	typedef struct packed {
		logic [CAP_W-1:0] cap;
		logic [CAP_W-1:0] fill;
		logic [PTR_W-1:0] head;
		logic [PTR_W-1:0] tail;
	} desc_t;

	// Update request to the channel allocator.
	typedef struct packed {
		logic set_open;
		logic clr_open;
	} alloc_op_t;

endpackage

[rtl/mcfp_ram.sv]
module mcfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/mcfp_alloc.sv]
module mcfp_alloc import mcfp_pkg::*; #(
	parameter int CHANNELS = 16,
	parameter int CW       = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  alloc_op_t     op,
	input  logic [CW-1:0] set_idx,
	input  logic [CW-1:0] clr_idx,
	input  logic [CW-1:0] query_idx,
	output logic          open_bit,
	output logic          free_found,
	output logic [CW-1:0] free_idx
);

	logic [CHANNELS-1:0] open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			if (op.set_open) begin
				open_q[set_idx] <= 1'b1;
			end
			if (op.clr_open) begin
				open_q[clr_idx] <= 1'b0;
			end
		end
	end

	assign open_bit = open_q[query_idx];

	// Priority encoder: the lowest closed channel wins.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				free_found = 1'b1;
				free_idx   = CW'(i);
			end
		end
	end

endmodule

[rtl/multi_channel_fifo_pool.sv]
// Pool of word queues sharing one word memory.
// Request channel (req_valid / req_stall) carries cmd, channel, data_word and
// requested_capacity. Create opens the lowest closed channel with the given
// capacity, send appends data_word, receive pops the oldest word and close
// frees the channel. Full or empty queues never block: the result reports a
// would-block status and nothing changes.
// Response channel (rsp_valid / rsp_stall) returns one item per request with
// status, channel_out, data_out, is_empty and is_full.
// An item's result is registered after a read of the channel descriptor memory
// and, for a receive that pops a word, a read of the word memory after it.
// The block works on one item at a time, so it takes no new item until the
// previous result has been loaded into the output register.
// Reset closes every channel; descriptor and word memories need no clearing
// because a channel's descriptor is written when it is opened.
// While the receiver stalls, a finished result waits in the output register;
// the block may still take the next item and hold it until the slot frees.
module multi_channel_fifo_pool import mcfp_pkg::*; #(
	parameter int CHANNELS     = 16,
	parameter int BUFFER_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  channel,
	input  logic [31:0] data_word,
	input  logic [8:0]  requested_capacity,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [3:0]  channel_out,
	output logic [31:0] data_out,
	output logic        is_empty,
	output logic        is_full
);

	localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WDEPTH = CHANNELS * BUFFER_DEPTH;
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int CMP_W  = 12;

	fsm_state_t state_q, state_d;

	// Accepted item.
	cmd_t              cmd_s1;
	logic [3:0]        chan_s1;
	logic [WORD_W-1:0] word_s1;
	logic [CAP_W-1:0]  cap_s1;

	// Flags carried into the pop cycle.
	logic pend_empty_q, pend_full_q;

	// Output register.
	logic              rsp_valid_q;
	status_t           status_q;
	logic [3:0]        chan_out_q;
	logic [WORD_W-1:0] data_out_q;
	logic              empty_q, full_q;

	logic accept, out_free;
	logic [CW-1:0] chan_idx;
	logic chan_in_range;

	// Descriptor memory.
	logic          desc_we;
	logic [CW-1:0] desc_waddr;
	desc_t         desc_wdata, desc_rd;
	logic [$bits(desc_t)-1:0] desc_rdata;

	// Word memory.
	logic              word_we, word_re;
	logic [WAW-1:0]    word_addr;
	logic [WORD_W-1:0] word_rdata;

	// Allocator.
	alloc_op_t     aop;
	logic          open_bit, free_found;
	logic [CW-1:0] free_idx;

	// Next result.
	logic              load_out;
	status_t           st_n;
	logic [3:0]        chan_out_n;
	logic [WORD_W-1:0] data_n;
	logic              empty_n, full_n;
	logic              pend_load;
	logic              pend_empty_n, pend_full_n;
	logic [PTR_W-1:0]  ptr_sel;
	logic [CAP_W-1:0]  next_tail, next_head;

	assign accept        = req_valid && !req_stall;
	assign out_free      = !rsp_valid_q || !rsp_stall;
	assign chan_idx      = CW'(chan_s1);
	assign chan_in_range = (CMP_W'(chan_s1) < CMP_W'(CHANNELS));
	assign desc_rd       = desc_t'(desc_rdata);

	// Circular advance of the tail and head pointers.
	assign next_tail = (CAP_W'(desc_rd.tail) + CAP_W'(1) >= desc_rd.cap) ? '0
		: CAP_W'(desc_rd.tail) + CAP_W'(1);
	assign next_head = (CAP_W'(desc_rd.head) + CAP_W'(1) >= desc_rd.cap) ? '0
		: CAP_W'(desc_rd.head) + CAP_W'(1);

	// Slot c*BUFFER_DEPTH+p of the shared word memory.
	assign word_addr = WAW'(chan_idx) * WAW'(BUFFER_DEPTH) + WAW'(ptr_sel);

	mcfp_alloc #(
		.CHANNELS(CHANNELS),
		.CW      (CW)
	) u_alloc (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (aop),
		.set_idx   (free_idx),
		.clr_idx   (chan_idx),
		.query_idx (chan_idx),
		.open_bit  (open_bit),
		.free_found(free_found),
		.free_idx  (free_idx)
	);

	mcfp_ram #(
		.WIDTH($bits(desc_t)),
		.DEPTH(CHANNELS)
	) u_desc_ram (
		.clk  (clk),
		.we   (desc_we),
		.waddr(desc_waddr),
		.wdata(desc_wdata),
		.re   (accept),
		.raddr(CW'(channel)),
		.rdata(desc_rdata)
	);

	mcfp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WDEPTH)
	) u_word_ram (
		.clk  (clk),
		.we   (word_we),
		.waddr(word_addr),
		.wdata(word_s1),
		.re   (word_re),
		.raddr(word_addr),
		.rdata(word_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(cmd);
			chan_s1 <= channel;
			word_s1 <= data_word;
			cap_s1  <= requested_capacity;
		end
		if (pend_load) begin
			pend_empty_q <= pend_empty_n;
			pend_full_q  <= pend_full_n;
		end
		if (load_out) begin
			status_q   <= st_n;
			chan_out_q <= chan_out_n;
			data_out_q <= data_n;
			empty_q    <= empty_n;
			full_q     <= full_n;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_stall    = 1'b1;
		load_out     = 1'b0;
		st_n         = ST_OK;
		chan_out_n   = '0;
		data_n       = '1;
		empty_n      = 1'b0;
		full_n       = 1'b0;
		pend_load    = 1'b0;
		pend_empty_n = 1'b0;
		pend_full_n  = 1'b0;
		desc_we      = 1'b0;
		desc_waddr   = chan_idx;
		desc_wdata   = desc_rd;
		word_we      = 1'b0;
		word_re      = 1'b0;
		ptr_sel      = desc_rd.tail;
		aop          = '0;

		unique case (state_q)
			FSM_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = FSM_EXEC;
				end
			end

			FSM_EXEC: begin
				if (cmd_s1 == CMD_CREATE) begin
					if (cap_s1 == '0 || CMP_W'(cap_s1) > CMP_W'(BUFFER_DEPTH)) begin
						st_n = ST_BAD_CAP;
					end else if (!free_found) begin
						st_n = ST_NO_FREE;
					end else begin
						chan_out_n = 4'(free_idx);
						empty_n    = 1'b1;
						desc_waddr = free_idx;
						desc_wdata = '{cap: cap_s1, fill: '0, head: '0, tail: '0};
						desc_we    = out_free;
						aop.set_open = out_free;
					end
					load_out = out_free;
				end else if (!chan_in_range || !open_bit) begin
					st_n     = ST_NOT_OPEN;
					load_out = out_free;
				end else begin
					case (cmd_s1)
						CMD_SEND: begin
							if (desc_rd.fill >= desc_rd.cap) begin
								st_n    = ST_FULL;
								empty_n = (desc_rd.fill == '0);
								full_n  = 1'b1;
							end else begin
								ptr_sel         = desc_rd.tail;
								desc_wdata.tail = PTR_W'(next_tail);
								desc_wdata.fill = desc_rd.fill + CAP_W'(1);
								desc_we         = out_free;
								word_we         = out_free;
								full_n = (desc_rd.fill + CAP_W'(1) >= desc_rd.cap);
							end
							load_out = out_free;
						end
						CMD_RECEIVE: begin
							if (desc_rd.fill == '0) begin
								st_n     = ST_EMPTY;
								empty_n  = 1'b1;
								load_out = out_free;
							end else begin
								// The word read lands next cycle; the
								// descriptor is committed now.
								ptr_sel         = desc_rd.head;
								desc_wdata.head = PTR_W'(next_head);
								desc_wdata.fill = desc_rd.fill - CAP_W'(1);
								desc_we         = 1'b1;
								word_re         = 1'b1;
								pend_load       = 1'b1;
								pend_empty_n    = (desc_rd.fill == CAP_W'(1));
								pend_full_n = (desc_rd.fill - CAP_W'(1) >= desc_rd.cap);
							end
						end
						default: begin
							empty_n      = 1'b1;
							aop.clr_open = out_free;
							load_out     = out_free;
						end
					endcase
				end

				if (load_out) begin
					state_d = FSM_IDLE;
				end else if (pend_load) begin
					state_d = FSM_POP;
				end
			end

			FSM_POP: begin
				data_n   = word_rdata;
				empty_n  = pend_empty_q;
				full_n   = pend_full_q;
				load_out = out_free;
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end

			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign channel_out = chan_out_q;
	assign data_out    = data_out_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;

endmodule

[verif/multi_channel_fifo_pool_tb.sv]
`timescale 1ns / 100ps

module multi_channel_fifo_pool_tb;
	import mcfp_pkg::*;

	localparam int CHANNELS     = 16;
	localparam int BUFFER_DEPTH = 256;
	// A long receiver hold-off must fit well inside the watchdog window.
	localparam int HOLD_CYCLES  = 200;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	// One result item as the block reports it.
	typedef struct {
		status_t     status;
		logic [3:0]  channel;
		logic [31:0] data;
		logic        empty;
		logic        full;
	} pool_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  cmd = '0;
	logic [3:0]  channel = '0;
	logic [31:0] data_word = '0;
	logic [8:0]  requested_capacity = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [2:0]  status;
	logic [3:0]  channel_out;
	logic [31:0] data_out;
	logic        is_empty;
	logic        is_full;

	// Shadow copy of the pool, updated as each request item is accepted.
	bit          chan_open [CHANNELS];
	logic [8:0]  chan_cap [CHANNELS];
	logic [8:0]  chan_fill [CHANNELS];
	logic [7:0]  chan_head [CHANNELS];
	logic [7:0]  chan_tail [CHANNELS];
	logic [31:0] queued_words [CHANNELS][BUFFER_DEPTH];

	pool_result_t pending_results[$];
	int           mismatches = 0;

	// Sender burst state, the receiver hold-off request and the receiver stall modes.
	int burst_left = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	logic [7:0] stall_pattern = '0;

	multi_channel_fifo_pool #(
		.CHANNELS(CHANNELS),
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.channel(channel),
		.data_word(data_word),
		.requested_capacity(requested_capacity),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.channel_out(channel_out),
		.data_out(data_out),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	always #5 clk = ~clk;

	// Ring pointers wrap at the channel's own capacity, not at the buffer depth.
	function automatic logic [7:0] next_ring_slot(logic [7:0] pos, logic [8:0] cap);
		int n;
		n = int'(pos) + 1;
		return (n >= int'(cap)) ? 8'd0 : n[7:0];
	endfunction

	// Applies one request to the shadow pool and returns the result it must produce.
	function automatic pool_result_t predict_pool_result(cmd_t op, logic [3:0] ch,
			logic [31:0] word, logic [8:0] cap);
		pool_result_t r;
		int slot;
		bit found;
		r.status = ST_OK;
		r.channel = '0;
		r.data = '1;
		r.empty = 1'b0;
		r.full = 1'b0;
		found = 1'b0;
		slot = 0;
		if (op == CMD_CREATE) begin
			// The capacity check comes before the search for a free channel.
			if (cap == 0 || cap > BUFFER_DEPTH) begin
				r.status = ST_BAD_CAP;
			end else begin
				for (int i = 0; i < CHANNELS && !found; i++) begin
					if (!chan_open[i]) begin
						found = 1'b1;
						slot = i;
					end
				end
				if (!found) begin
					r.status = ST_NO_FREE;
				end else begin
					chan_open[slot] = 1'b1;
					chan_cap[slot] = cap;
					chan_fill[slot] = '0;
					chan_head[slot] = '0;
					chan_tail[slot] = '0;
					r.channel = slot[3:0];
					r.empty = 1'b1;
				end
			end
		end else if (!chan_open[ch]) begin
			r.status = ST_NOT_OPEN;
		end else if (op == CMD_CLOSE) begin
			chan_open[ch] = 1'b0;
			chan_fill[ch] = '0;
			r.empty = 1'b1;
		end else begin
			if (op == CMD_SEND) begin
				if (chan_fill[ch] >= chan_cap[ch]) begin
					r.status = ST_FULL;
				end else begin
					queued_words[ch][chan_tail[ch]] = word;
					chan_tail[ch] = next_ring_slot(chan_tail[ch], chan_cap[ch]);
					chan_fill[ch] = chan_fill[ch] + 1'b1;
				end
			end else begin
				if (chan_fill[ch] == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = queued_words[ch][chan_head[ch]];
					chan_head[ch] = next_ring_slot(chan_head[ch], chan_cap[ch]);
					chan_fill[ch] = chan_fill[ch] - 1'b1;
				end
			end
			r.empty = (chan_fill[ch] == 0);
			r.full = (chan_fill[ch] >= chan_cap[ch]);
		end
		return r;
	endfunction

	// Mostly picks an open channel so that sequences get past the not-open check.
	function automatic logic [3:0] pick_channel(int open_pct);
		logic [3:0] opened[$];
		for (int i = 0; i < CHANNELS; i++) begin
			if (chan_open[i]) begin
				opened.push_back(i[3:0]);
			end
		end
		if (opened.size() > 0 && $urandom_range(0, 99) < open_pct) begin
			return opened[$urandom_range(0, opened.size() - 1)];
		end
		return 4'($urandom_range(0, CHANNELS - 1));
	endfunction

	// Capacities lean small so that full and empty cases come up often.
	function automatic logic [8:0] pick_capacity();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 9'($urandom_range(1, 8));
		end else if (r < 88) begin
			return 9'($urandom_range(1, BUFFER_DEPTH));
		end
		return 9'($urandom_range(0, 511));
	endfunction

	// Offers one request item and waits until the block takes it. Items come in
	// bursts of random length; between bursts valid drops for a random gap, and
	// a quarter of the bursts follow the previous one with no gap at all.
	task automatic send_item(cmd_t op, logic [3:0] ch, logic [31:0] word,
			logic [8:0] cap);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		cmd <= op;
		channel <= ch;
		data_word <= word;
		requested_capacity <= cap;
		do @(posedge clk); while (req_stall);
		pending_results.push_back(predict_pool_result(op, ch, word, cap));
	endtask

	// A random queue operation, biased toward open channels.
	task automatic send_random_op(int create_pct, int close_pct);
		int r;
		cmd_t op;
		r = $urandom_range(0, 99);
		if (r < create_pct) begin
			op = CMD_CREATE;
		end else if (r >= 100 - close_pct) begin
			op = CMD_CLOSE;
		end else if (r % 2 == 0) begin
			op = CMD_SEND;
		end else begin
			op = CMD_RECEIVE;
		end
		send_item(op, pick_channel(88), $urandom(), pick_capacity());
	endtask

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Capacity limits on create: zero and anything above the buffer depth are
	// rejected, the depth itself and a single word are accepted.
	task automatic test_create_checks();
		send_item(CMD_CREATE, 4'd0, 32'd0, 9'd0);
		send_item(CMD_CREATE, 4'd15, 32'hFFFF_FFFF, 9'd257);
		send_item(CMD_CREATE, 4'd9, 32'd0, 9'd511);
		send_item(CMD_CREATE, 4'd0, 32'd0, 9'd256);
		send_item(CMD_CREATE, 4'd0, 32'd0, 9'd1);
	endtask

	// Send, receive and close to channels that were never opened.
	task automatic test_closed_channel();
		send_item(CMD_SEND, 4'd15, 32'h1234_5678, 9'd0);
		send_item(CMD_RECEIVE, 4'd14, 32'd0, 9'd0);
		send_item(CMD_CLOSE, 4'd13, 32'd0, 9'd0);
	endtask

	// Word extremes through the two open channels, plus full on send and empty
	// on receive on the one-word channel.
	task automatic test_word_extremes();
		send_item(CMD_SEND, 4'd1, 32'h7FFF_FFFF, 9'd0);
		send_item(CMD_SEND, 4'd1, 32'h0000_0000, 9'd0);
		send_item(CMD_RECEIVE, 4'd1, 32'd0, 9'd0);
		send_item(CMD_RECEIVE, 4'd1, 32'd0, 9'd0);
		send_item(CMD_SEND, 4'd0, 32'h8000_0000, 9'd0);
		send_item(CMD_SEND, 4'd0, 32'hFFFF_FFFF, 9'd0);
		send_item(CMD_RECEIVE, 4'd0, 32'd0, 9'd0);
		send_item(CMD_RECEIVE, 4'd0, 32'd0, 9'd0);
		send_item(CMD_CLOSE, 4'd0, 32'd0, 9'd0);
		send_item(CMD_CLOSE, 4'd1, 32'd0, 9'd0);
	endtask

	// Opens every channel, asks for one more, then checks that a freed channel
	// in the middle is the next one handed out.
	task automatic test_pool_exhaustion();
		for (int i = 0; i <= CHANNELS; i++) begin
			send_item(CMD_CREATE, 4'($urandom()), $urandom(), 9'($urandom_range(1, 4)));
		end
		repeat (20) send_random_op(0, 0);
		send_item(CMD_CLOSE, 4'd7, $urandom(), 9'($urandom()));
		send_item(CMD_CREATE, 4'($urandom()), $urandom(), 9'd2);
		for (int i = 0; i < CHANNELS; i++) begin
			send_item(CMD_CLOSE, i[3:0], $urandom(), 9'($urandom()));
		end
	endtask

	// Fills a full-depth channel past its capacity so that both pointers wrap,
	// then drains it past empty. Every channel is closed here, so the create
	// lands on channel zero.
	task automatic test_full_size_channel();
		send_item(CMD_CREATE, 4'd0, 32'd0, 9'd256);
		repeat (BUFFER_DEPTH + 1) send_item(CMD_SEND, 4'd0, $urandom(), 9'($urandom()));
		repeat (BUFFER_DEPTH + 1) send_item(CMD_RECEIVE, 4'd0, $urandom(), 9'($urandom()));
		send_item(CMD_CLOSE, 4'd0, 32'd0, 9'd0);
	endtask

	// The receiver holds off for a long stretch while requests keep coming, so
	// the output register and the request slot fill and the block stalls its
	// input.
	task automatic test_backpressure();
		repeat (3) send_item(CMD_CREATE, 4'd0, $urandom(), 9'd4);
		hold_request = 1'b1;
		repeat (40) send_random_op(0, 0);
	endtask

	task automatic test_random_traffic(int count);
		repeat (count) send_random_op(12, 6);
	endtask

	// Receiver: a rotating stall pattern, a random dense stall mode and
	// stretches with no stall, each mode lasting a random number of cycles.
	// A hold-off request overrides all of them.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 96);
				stall_pattern = 8'($urandom());
			end
			mode_left--;
			stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
			case (stall_mode)
				0: begin
					rsp_stall <= 1'b0;
				end
				1: begin
					rsp_stall <= stall_pattern[0];
				end
				default: begin
					rsp_stall <= ($urandom_range(0, 3) != 0);
				end
			endcase
		end
	end

	// Every accepted result item is compared with the oldest expectation.
	always @(posedge clk) begin : result_check
		pool_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %h data %h", $time,
					status, data_out);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				report_field("status", 32'(want.status), 32'(status));
				report_field("channel_out", 32'(want.channel), 32'(channel_out));
				report_field("data_out", want.data, data_out);
				report_field("is_empty", 32'(want.empty), 32'(is_empty));
				report_field("is_full", 32'(want.full), 32'(is_full));
			end
		end
	end

	// Watchdog: ends the run once too many cycles pass with no item moving on
	// either channel.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t: timeout with %0d results outstanding", $time,
			pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		test_create_checks();
		test_closed_channel();
		test_word_extremes();
		test_pool_exhaustion();
		test_full_size_channel();
		test_backpressure();
		test_random_traffic(250);

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		// Any stray result after the last expected one is caught meanwhile.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
